// ===== rtl/core/brb_pkg.sv =====
// Shared types and constants for the byte ring buffer FIFO.
// No dependencies; used by brb_ctrl, brb_dp and byte_ring_buffer_fifo.
`timescale 1ns / 1ps

package brb_pkg;

  // Default geometry
  localparam int DEPTH_DEF     = 256;
  localparam int MAX_BURST_DEF = 64;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_PUT  = 2'd0,
    OP_GET  = 2'd1,
    OP_PEEK = 2'd2,
    OP_SKIP = 2'd3
  } op_t;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;

  // Controller -> datapath commands
  typedef struct packed {
    logic cap;   // latch request fields
    logic exec;  // evaluate request, update pointers and counts
    logic rd;    // issue one memory read, advance burst pointer
    logic emit;  // a read byte is on the result port
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic burst; // request produces a run of read bytes
    logic more;  // burst bytes still to read
  } stat_t;

endpackage

// ===== rtl/core/brb_ctrl.sv =====
// Sequencing state machine for the byte ring buffer FIFO.
// Depends on brb_pkg (cmd_t, stat_t).
`timescale 1ns / 1ps

module brb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  output logic           res_valid,
  input  logic           res_ready,
  input  brb_pkg::stat_t stat,
  output brb_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_RESP = 5'b00100,
    S_RD   = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state, state_next;

  // Next-state logic
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (req_valid) state_next = S_EXEC;
      S_EXEC: state_next = stat.burst ? S_RD : S_RESP;
      S_RESP: if (res_ready) state_next = S_IDLE;
      S_RD:   state_next = S_EMIT;
      S_EMIT: begin
        if (res_ready) state_next = stat.more ? S_RD : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Handshake and command decode
  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_RESP) || (state == S_EMIT);

  always_comb begin
    cmd.cap  = (state == S_IDLE) && req_valid;
    cmd.exec = (state == S_EXEC);
    cmd.rd   = (state == S_RD);
    cmd.emit = (state == S_EMIT);
  end

endmodule

// ===== rtl/core/brb_dp.sv =====
// Datapath of the byte ring buffer FIFO: byte memory, pointers, run tracking.
// Depends on brb_pkg (op codes, status codes, cmd_t, stat_t).
`timescale 1ns / 1ps

module brb_dp #(
  parameter int DEPTH     = brb_pkg::DEPTH_DEF,
  parameter int MAX_BURST = brb_pkg::MAX_BURST_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  brb_pkg::cmd_t  cmd,
  output brb_pkg::stat_t stat,
  input  logic [1:0]     op,
  input  logic [7:0]     data_byte,
  input  logic           run_first,
  input  logic [7:0]     length,
  input  logic [7:0]     offset,
  output logic [7:0]     read_byte,
  output logic           byte_valid,
  output logic           last,
  output logic [1:0]     status,
  output logic [7:0]     used_count,
  output logic [7:0]     free_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = ((AW > 8) ? AW : 8) + 1;
  localparam int BW = $clog2(MAX_BURST + 1);
  localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] FREE_MAX = CW'(DEPTH - 1);
  localparam logic [CW-1:0] BURST_W  = CW'(MAX_BURST);
  localparam logic [CW-1:0] SAT_W    = CW'(255);

  // Latched request
  brb_pkg::op_t op_q;
  logic [7:0]   data_q;
  logic         first_q;
  logic [7:0]   len_q;
  logic [7:0]   off_q;

  // Buffer state
  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata;
  logic [AW-1:0] wr_idx, wr_next;
  logic [AW-1:0] rd_idx, rd_next;
  logic [AW-1:0] used, used_next;
  logic [7:0]    run_rem, rem_next;
  logic          run_acc, acc_next;
  logic [AW-1:0] rd_ptr, ptr_next;
  logic [BW-1:0] burst_left, left_next;
  logic [1:0]    res_status, status_next;
  logic          store_en;
  logic          burst;

  // Widened views for compares
  logic [CW-1:0] used_w, free_w, len_w, cnt_w, start_w, avail_w, n_w, skip_n;

  function automatic logic [AW-1:0] add_mod(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_W) s = s - DEPTH_W;
    return s[AW-1:0];
  endfunction

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_q    <= brb_pkg::op_t'(op);
      data_q  <= data_byte;
      first_q <= run_first;
      len_q   <= length;
      off_q   <= offset;
    end
  end

  // Counts and limits
  always_comb begin
    used_w  = CW'(used);
    free_w  = FREE_MAX - used_w;
    len_w   = CW'(len_q);
    cnt_w   = (len_w > BURST_W) ? BURST_W : len_w;
    start_w = (op_q == brb_pkg::OP_GET) ? '0 : CW'(off_q);
    avail_w = used_w - start_w;
    n_w     = (cnt_w < avail_w) ? cnt_w : avail_w;
    skip_n  = (len_w < used_w) ? len_w : used_w;
  end

  // Request evaluation and burst stepping
  always_comb begin
    wr_next     = wr_idx;
    rd_next     = rd_idx;
    used_next   = used;
    rem_next    = run_rem;
    acc_next    = run_acc;
    ptr_next    = rd_ptr;
    left_next   = burst_left;
    status_next = res_status;
    store_en    = 1'b0;
    burst       = 1'b0;
    if (cmd.exec) begin
      status_next = brb_pkg::ST_OK;
      case (op_q)
        brb_pkg::OP_PUT: begin
          if (first_q) begin
            if (len_q == 8'd0) begin
              rem_next = 8'd0;
              acc_next = 1'b0;
            end else if (len_w <= free_w) begin
              acc_next = 1'b1;
              rem_next = len_q - 8'd1;
              if (free_w != '0) store_en = 1'b1;
              else              status_next = brb_pkg::ST_REJECT;
            end else begin
              acc_next    = 1'b0;
              rem_next    = len_q - 8'd1;
              status_next = brb_pkg::ST_REJECT;
            end
          end else if (run_rem == 8'd0) begin
            status_next = brb_pkg::ST_REJECT;
          end else begin
            rem_next = run_rem - 8'd1;
            if (!run_acc || free_w == '0) status_next = brb_pkg::ST_REJECT;
            else                          store_en = 1'b1;
          end
        end
        brb_pkg::OP_SKIP: begin
          rd_next   = add_mod(rd_idx, AW'(skip_n));
          used_next = used - AW'(skip_n);
        end
        default: begin
          // get and peek
          if (start_w >= used_w) begin
            status_next = brb_pkg::ST_EMPTY;
          end else if (n_w != '0) begin
            burst     = 1'b1;
            ptr_next  = add_mod(rd_idx, AW'(start_w));
            left_next = BW'(n_w);
            if (op_q == brb_pkg::OP_GET) begin
              rd_next   = add_mod(rd_idx, AW'(n_w));
              used_next = used - AW'(n_w);
            end
          end
        end
      endcase
      if (store_en) begin
        wr_next   = add_mod(wr_idx, AW'(1));
        used_next = used + AW'(1);
      end
    end
    if (cmd.rd) begin
      ptr_next  = add_mod(rd_ptr, AW'(1));
      left_next = burst_left - BW'(1);
    end
  end

  // Control state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx     <= '0;
      rd_idx     <= '0;
      used       <= '0;
      run_rem    <= '0;
      run_acc    <= 1'b0;
      rd_ptr     <= '0;
      burst_left <= '0;
      res_status <= brb_pkg::ST_OK;
    end else begin
      wr_idx     <= wr_next;
      rd_idx     <= rd_next;
      used       <= used_next;
      run_rem    <= rem_next;
      run_acc    <= acc_next;
      rd_ptr     <= ptr_next;
      burst_left <= left_next;
      res_status <= status_next;
    end
  end

  // Byte memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (store_en) mem[wr_idx] <= data_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) rdata <= mem[rd_ptr];
  end

  // Status to controller
  always_comb begin
    stat.burst = burst;
    stat.more  = (burst_left != '0);
  end

  // Result fields
  assign byte_valid = cmd.emit;
  assign read_byte  = cmd.emit ? rdata : 8'd0;
  assign last       = cmd.emit ? (burst_left == '0) : 1'b1;
  assign status     = cmd.emit ? brb_pkg::ST_OK : res_status;
  assign used_count = (used_w > SAT_W) ? 8'hFF : used_w[7:0];
  assign free_count = (free_w > SAT_W) ? 8'hFF : free_w[7:0];

  // Checks
  a_used_matches_ptrs: assert property (@(posedge clk) disable iff (rst)
    used == ((wr_idx >= rd_idx) ? (wr_idx - rd_idx)
                                : AW'({1'b0, wr_idx} + DEPTH_W - {1'b0, rd_idx})))
    else $error("used count disagrees with write and read indexes");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_w <= FREE_MAX)
    else $error("buffer holds more than DEPTH-1 bytes");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, wr_idx} < DEPTH_W) && ({1'b0, rd_idx} < DEPTH_W) && ({1'b0, rd_ptr} < DEPTH_W))
    else $error("index outside the buffer");

  a_burst_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && burst |=> (burst_left <= BW'(MAX_BURST)) && (burst_left != '0))
    else $error("burst length out of range");

endmodule

// ===== rtl/core/byte_ring_buffer_fifo.sv =====
// Top level of the byte ring buffer FIFO.
// Depends on brb_pkg, brb_ctrl and brb_dp.
//
//   channel   handshake              payload
//   request   req_valid / req_ready  op, data_byte, run_first, length, offset
//   result    res_valid / res_ready  read_byte, byte_valid, last, status,
//                                    used_count, free_count
//
// A put or skip is accepted, evaluated and then answered with a result.
// A get or peek that returns bytes is accepted and evaluated, then each byte
// takes a memory read and then a result, set by the single registered read
// port of the byte memory; one that returns no byte is handled like a put.
// Synchronous reset empties the buffer and clears any pending put run.
// A stalled result holds the block; no request is taken until the last
// result of the current one is delivered.
`timescale 1ns / 1ps

module byte_ring_buffer_fifo #(
  parameter int DEPTH     = brb_pkg::DEPTH_DEF,
  parameter int MAX_BURST = brb_pkg::MAX_BURST_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  logic [1:0] op,
  input  logic [7:0] data_byte,
  input  logic       run_first,
  input  logic [7:0] length,
  input  logic [7:0] offset,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [7:0] read_byte,
  output logic       byte_valid,
  output logic       last,
  output logic [1:0] status,
  output logic [7:0] used_count,
  output logic [7:0] free_count
);

  brb_pkg::cmd_t  cmd;
  brb_pkg::stat_t stat;

  // Sequencer
  brb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Buffer datapath
  brb_dp #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .op         (op),
    .data_byte  (data_byte),
    .run_first  (run_first),
    .length     (length),
    .offset     (offset),
    .read_byte  (read_byte),
    .byte_valid (byte_valid),
    .last       (last),
    .status     (status),
    .used_count (used_count),
    .free_count (free_count)
  );

endmodule
